@@ src/assert_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define BMPW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define BMPW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ src/bmpw_pkg.sv @@
package bmpw_pkg;

  localparam int LVL_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int PROD_W     = 31;
  localparam int DIM_W      = 13;
  localparam int COUNT_W    = 24;
  localparam int TOTAL_W    = 25;
  localparam int SIZE_W     = 26;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ROM_SIZE   = 254;
  localparam int THR_W      = 32;

  localparam int HEADER_BYTES = 54;
  localparam int MAX_DIM      = 4096;
  localparam int IDX_W        = 6;

  // Byte positions inside the work of one pixel: header, then blue, green, red.
  localparam logic [IDX_W-1:0] PIX_POS  = IDX_W'(HEADER_BYTES);
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(HEADER_BYTES + 2);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd2;

  // Header field positions and fixed values.
  localparam logic [IDX_W-1:0] HDR_SIG0    = 6'd0;
  localparam logic [IDX_W-1:0] HDR_SIG1    = 6'd1;
  localparam logic [IDX_W-1:0] HDR_SIZE0   = 6'd2;
  localparam logic [IDX_W-1:0] HDR_SIZE1   = 6'd3;
  localparam logic [IDX_W-1:0] HDR_SIZE2   = 6'd4;
  localparam logic [IDX_W-1:0] HDR_SIZE3   = 6'd5;
  localparam logic [IDX_W-1:0] HDR_OFFSET  = 6'd10;
  localparam logic [IDX_W-1:0] HDR_DIB     = 6'd14;
  localparam logic [IDX_W-1:0] HDR_WIDTH0  = 6'd18;
  localparam logic [IDX_W-1:0] HDR_WIDTH1  = 6'd19;
  localparam logic [IDX_W-1:0] HDR_HEIGHT0 = 6'd22;
  localparam logic [IDX_W-1:0] HDR_HEIGHT1 = 6'd23;
  localparam logic [IDX_W-1:0] HDR_PLANES  = 6'd26;
  localparam logic [IDX_W-1:0] HDR_BPP     = 6'd28;

  localparam logic [7:0] SIG_B      = 8'h42;
  localparam logic [7:0] SIG_M      = 8'h4D;
  localparam logic [7:0] DATA_OFS   = 8'd54;
  localparam logic [7:0] DIB_SIZE   = 8'd40;
  localparam logic [7:0] PLANES     = 8'd1;
  localparam logic [7:0] BITS_PIXEL = 8'd24;

  localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
  localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C234;
  localparam logic [63:0] STEP_Q62 = PI_Q62 / 64'd510;

  typedef logic [ROM_SIZE-1:0][THR_W-1:0] tone_rom_t;

  // (a*b) >> 62, truncated to 64 bits.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // ceil(65536 * s / c) by restoring long division.
  function automatic logic [31:0] ceil_ratio16(input logic [63:0] s, input logic [63:0] c);
    logic [79:0] num;
    logic [79:0] q;
    logic [64:0] r;
    num = {s, 16'd0};
    q = '0;
    r = '0;
    if (c == 64'd0) begin
      return 32'hFFFF_FFFF;
    end
    for (int i = 79; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, c}) begin
        r = r - {1'b0, c};
        q[i] = 1'b1;
      end
    end
    if (r != 65'd0) begin
      q = q + 80'd1;
    end
    return q[31:0];
  endfunction

  // Thresholds ceil(65536*tan(j*pi/510)), j = 1..254, by an angle-step rotation.
  function automatic tone_rom_t build_tone_rom();
    tone_rom_t   rom;
    logic [63:0] d2;
    logic [63:0] s1;
    logic [63:0] c1;
    logic [63:0] t;
    logic [63:0] sj;
    logic [63:0] cj;
    logic [63:0] ns;
    logic [63:0] nc;
    d2 = mul_q62(STEP_Q62, STEP_Q62);
    s1 = STEP_Q62;
    t  = STEP_Q62;
    t  = mul_q62(t, d2) / 64'd6;
    s1 = s1 - t;
    t  = mul_q62(t, d2) / 64'd20;
    s1 = s1 + t;
    t  = mul_q62(t, d2) / 64'd42;
    s1 = s1 - t;
    t  = mul_q62(t, d2) / 64'd72;
    s1 = s1 + t;
    c1 = Q62_ONE;
    t  = Q62_ONE;
    t  = mul_q62(t, d2) / 64'd2;
    c1 = c1 - t;
    t  = mul_q62(t, d2) / 64'd12;
    c1 = c1 + t;
    t  = mul_q62(t, d2) / 64'd30;
    c1 = c1 - t;
    t  = mul_q62(t, d2) / 64'd56;
    c1 = c1 + t;
    sj = '0;
    cj = Q62_ONE;
    for (int j = 0; j < ROM_SIZE; j++) begin
      nc = mul_q62(cj, c1) - mul_q62(sj, s1);
      ns = mul_q62(sj, c1) + mul_q62(cj, s1);
      cj = nc;
      sj = ns;
      rom[j] = ceil_ratio16(sj, cj);
    end
    return rom;
  endfunction

  localparam tone_rom_t TONE_ROM = build_tone_rom();

  // A dimension of zero counts as one, anything above the maximum as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

endpackage

@@ src/bmpw_if.sv @@
interface bmpw_pix_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] red_level;
  logic signed [15:0] green_level;
  logic signed [15:0] blue_level;

  modport source(output valid, output red_level, output green_level, output blue_level,
                 input ready);
  modport sink(input valid, input red_level, input green_level, input blue_level,
               output ready);
endinterface

interface bmpw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_item;
  logic       frame_done;

  modport source(output valid, output out_byte, output last_of_item, output frame_done,
                 input ready);
  modport sink(input valid, input out_byte, input last_of_item, input frame_done,
               output ready);
endinterface

@@ src/bmpw_tone_map.sv @@
module bmpw_tone_map (
  input  logic [bmpw_pkg::PROD_W-1:0] prod_i,
  output logic [7:0]                  level_o
);
  import bmpw_pkg::*;

  // reach[k] is set when the product reaches at least k thresholds.
  logic [255:0] reach;
  logic [7:0]   k;

  always_comb begin
    reach    = '0;
    reach[0] = 1'b1;
    for (int j = 0; j < ROM_SIZE; j++) begin
      reach[j+1] = ({1'b0, prod_i} >= TONE_ROM[j]);
    end
    // The thresholds rise, so reach is a thermometer code; find its top by bisection.
    k = '0;
    for (int b = 7; b >= 0; b--) begin
      if (reach[k | (8'd1 << b)]) begin
        k = k | (8'd1 << b);
      end
    end
    level_o = k;
  end

endmodule

@@ src/bmp_stream_writer_atan_tonemap_top.sv @@
// 24-bit BMP byte-stream writer with an arctangent tone map.
// pix_i takes one pixel per transfer as three signed Q8.8 levels. Each level is
// clamped at zero, scaled by the Q8.8 brightness gain and mapped to a byte
// floor(510/pi * atan(v)). byte_o gives the stream one byte per transfer: blue,
// green, red for each pixel, with the 54-byte BMP header put in front of the
// first pixel of every frame. last_of_item marks the red byte of each pixel and
// frame_done the red byte of a frame's last pixel.
// A pixel is registered in the pixel slot, and the sequencer moves its bytes
// one at a time into the output register that drives byte_o. A pixel occupies
// the byte sequencer for its three bytes, or 57 when it opens a frame; the next
// pixel can be taken in the cycle its predecessor's last byte enters the output
// register.
// After a configuration write, pix_i is held off while the derived frame size
// and pixel total settle.
// Reset sets width and height to 1, gain to 1.0 and the pixel count to zero, so
// the first pixel after reset opens a frame. When byte_o is stalled the output
// register holds its byte and the sequencer waits; pix_i keeps taking a pixel
// only while the pixel slot is free.
module bmp_stream_writer_atan_tonemap_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bmpw_pix_if.sink                        pix_i,
  bmpw_byte_if.source                     byte_o,
  input  logic                            cfg_we_i,
  input  logic [bmpw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bmpw_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bmpw_pkg::*;

  `include "assert_macros.svh"

  // Configuration registers and the values derived from them.
  logic [DIM_W-1:0]   width_q;
  logic [DIM_W-1:0]   height_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [DIM_W-1:0]   wc_q;
  logic [DIM_W-1:0]   hc_q;
  logic [TOTAL_W-1:0] total_q;
  logic [SIZE_W-1:0]  size_q;
  logic [1:0]         hold_q;

  // Frame position.
  logic [COUNT_W-1:0] count_q;
  logic [COUNT_W-1:0] count_d;
  logic               done_d;

  // Pixel slot: the pixel whose bytes the sequencer is producing.
  logic               slot_valid_q;
  logic [IDX_W-1:0]   slot_idx_q;
  logic               slot_done_q;
  logic [PROD_W-1:0]  prod_b_q;
  logic [PROD_W-1:0]  prod_g_q;
  logic [PROD_W-1:0]  prod_r_q;

  // Output register.
  logic               out_valid_q;
  logic [7:0]         out_byte_q;
  logic               out_last_q;
  logic               out_done_q;

  logic               pix_fire;
  logic               step;
  logic               slot_end;
  logic [PROD_W-1:0]  prod_sel;
  logic [7:0]         tone_byte;
  logic [7:0]         byte_d;

  function automatic logic [PROD_W-1:0] scale(input logic [LVL_W-1:0] lvl,
                                              input logic [GAIN_W-1:0] gain);
    logic [LVL_W-2:0] mag;
    mag = lvl[LVL_W-1] ? '0 : lvl[LVL_W-2:0];
    return PROD_W'(mag) * PROD_W'(gain);
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0]  idx,
                                          input logic [DIM_W-1:0]  w,
                                          input logic [DIM_W-1:0]  h,
                                          input logic [SIZE_W-1:0] size);
    logic [7:0] b;
    b = 8'd0;
    case (idx)
      HDR_SIG0:    b = SIG_B;
      HDR_SIG1:    b = SIG_M;
      HDR_SIZE0:   b = size[7:0];
      HDR_SIZE1:   b = size[15:8];
      HDR_SIZE2:   b = size[23:16];
      HDR_SIZE3:   b = 8'(size[SIZE_W-1:24]);
      HDR_OFFSET:  b = DATA_OFS;
      HDR_DIB:     b = DIB_SIZE;
      HDR_WIDTH0:  b = w[7:0];
      HDR_WIDTH1:  b = 8'(w[DIM_W-1:8]);
      HDR_HEIGHT0: b = h[7:0];
      HDR_HEIGHT1: b = 8'(h[DIM_W-1:8]);
      HDR_PLANES:  b = PLANES;
      HDR_BPP:     b = BITS_PIXEL;
      default:     b = 8'd0;
    endcase
    return b;
  endfunction

  // Configuration writes. The derived values follow through registers, the frame size last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      gain_q   <= GAIN_W'(256);
      wc_q     <= DIM_W'(1);
      hc_q     <= DIM_W'(1);
      total_q  <= TOTAL_W'(1);
      size_q   <= SIZE_W'(3);
      hold_q   <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
          CFG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
          CFG_GAIN:   gain_q   <= cfg_data_i[GAIN_W-1:0];
          default:    ;
        endcase
      end
      wc_q    <= clamp_dim(width_q);
      hc_q    <= clamp_dim(height_q);
      total_q <= TOTAL_W'(clamp_dim(width_q)) * TOTAL_W'(clamp_dim(height_q));
      size_q  <= SIZE_W'({total_q, 1'b0}) + SIZE_W'(total_q);
      if (cfg_we_i) begin
        hold_q <= 2'd2;
      end else if (hold_q != 2'd0) begin
        hold_q <= hold_q - 2'd1;
      end
    end
  end

  // The sequencer moves one byte into the output register whenever it has room.
  assign step     = slot_valid_q && (!out_valid_q || byte_o.ready);
  assign slot_end = step && (slot_idx_q == LAST_POS);
  assign pix_i.ready = (hold_q == 2'd0) && (!slot_valid_q || slot_end);
  assign pix_fire    = pix_i.valid && pix_i.ready;

  // A pixel ends the frame once the count reaches the current total.
  always_comb begin
    done_d  = ({1'b0, count_q} + TOTAL_W'(1)) >= total_q;
    count_d = done_d ? '0 : count_q + COUNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      slot_valid_q <= 1'b0;
      slot_idx_q   <= '0;
    end else begin
      if (pix_fire) begin
        count_q      <= count_d;
        slot_valid_q <= 1'b1;
        slot_idx_q   <= (count_q == '0) ? '0 : PIX_POS;
      end else if (slot_end) begin
        slot_valid_q <= 1'b0;
      end else if (step) begin
        slot_idx_q <= slot_idx_q + IDX_W'(1);
      end
    end
  end

  // Scaled channel levels are registered with the pixel.
  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      prod_b_q    <= scale(pix_i.blue_level, gain_q);
      prod_g_q    <= scale(pix_i.green_level, gain_q);
      prod_r_q    <= scale(pix_i.red_level, gain_q);
      slot_done_q <= done_d;
    end
  end

  always_comb begin
    if (slot_idx_q == PIX_POS) begin
      prod_sel = prod_b_q;
    end else if (slot_idx_q == PIX_POS + IDX_W'(1)) begin
      prod_sel = prod_g_q;
    end else begin
      prod_sel = prod_r_q;
    end
  end

  bmpw_tone_map u_tone (
    .prod_i  (prod_sel),
    .level_o (tone_byte)
  );

  assign byte_d = (slot_idx_q < PIX_POS) ? hdr_byte(slot_idx_q, wc_q, hc_q, size_q)
                                         : tone_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (byte_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_byte_q <= byte_d;
      out_last_q <= (slot_idx_q == LAST_POS);
      out_done_q <= (slot_idx_q == LAST_POS) && slot_done_q;
    end
  end

  assign byte_o.valid        = out_valid_q;
  assign byte_o.out_byte     = out_byte_q;
  assign byte_o.last_of_item = out_last_q;
  assign byte_o.frame_done   = out_done_q;

  `BMPW_ASSERT(a_done_is_last, (out_valid_q && out_done_q) |-> out_last_q, "done not last")
  `BMPW_ASSERT(a_idx_range, slot_valid_q |-> (slot_idx_q <= LAST_POS), "slot index out of range")
  `BMPW_ASSERT(a_frame_start, (pix_fire && (count_q == '0)) |=> (slot_idx_q == '0), "no header")
  `BMPW_ASSERT(a_slot_fill, pix_fire |=> slot_valid_q, "accepted pixel lost")
  `BMPW_ASSERT_ALWAYS(a_hold_range, hold_q != 2'd3, "configuration hold counter corrupt")

endmodule

@@ bench/bmpw_stream_checker.sv @@
`timescale 1ns / 100ps

// Watches the pixel, byte and register ports of the BMP stream writer, predicts
// the byte stream on its own and compares every byte transfer with it.
module bmpw_stream_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bmpw_pix_if                             pix_i,
  bmpw_byte_if                            byte_i,
  input  logic                            cfg_we_i,
  input  logic [bmpw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bmpw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                     mismatches_o,
  output int unsigned                     pending_o,
  output int unsigned                     pixels_o,
  output int unsigned                     bytes_o,
  output int unsigned                     frames_o
);
  import bmpw_pkg::*;

  localparam logic [63:0] Q62_UNIT     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_TURN    = 64'hC90F_DAA2_2168_C234;
  localparam logic [7:0]  MAGIC_B      = 8'h42;
  localparam logic [7:0]  MAGIC_M      = 8'h4D;
  localparam logic [31:0] INFO_HDR_LEN = 32'd40;
  localparam logic [15:0] PLANE_COUNT  = 16'd1;
  localparam logic [15:0] COLOR_DEPTH  = 16'd24;
  localparam int unsigned PRINT_CAP    = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last_pix;
    logic       frame_end;
  } bmp_byte_t;

  bmp_byte_t   stream_fifo[$];
  bmp_byte_t   want;
  logic [31:0] atan_thr [ROM_SIZE];
  logic [12:0] width_q;
  logic [12:0] height_q;
  logic [15:0] gain_q;
  logic [23:0] frame_pos;
  int unsigned fail_cnt;
  int unsigned pix_cnt;
  int unsigned byte_cnt;
  int unsigned frame_cnt;

  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod >> 62);
  endfunction

  // Thresholds of the arctangent curve: 65536*tan(j*pi/510), rounded up, found
  // by stepping a sine/cosine pair through the angle in Q2.62.
  initial begin : build_thresholds
    logic [63:0] step;
    logic [63:0] step_sq;
    logic [63:0] sin1;
    logic [63:0] cos1;
    logic [63:0] term;
    logic [63:0] sin_j;
    logic [63:0] cos_j;
    logic [63:0] cos_next;
    logic [79:0] num;
    logic [79:0] quo;
    step    = HALF_TURN / 64'd510;
    step_sq = q62_mul(step, step);
    sin1    = step;
    term    = step;
    for (int n = 1; n <= 4; n++) begin
      term = q62_mul(term, step_sq) / 64'((2 * n) * (2 * n + 1));
      sin1 = (n % 2 == 1) ? sin1 - term : sin1 + term;
    end
    cos1 = Q62_UNIT;
    term = Q62_UNIT;
    for (int n = 1; n <= 4; n++) begin
      term = q62_mul(term, step_sq) / 64'((2 * n - 1) * (2 * n));
      cos1 = (n % 2 == 1) ? cos1 - term : cos1 + term;
    end
    sin_j = '0;
    cos_j = Q62_UNIT;
    for (int j = 0; j < ROM_SIZE; j++) begin
      cos_next = q62_mul(cos_j, cos1) - q62_mul(sin_j, sin1);
      sin_j    = q62_mul(sin_j, cos1) + q62_mul(cos_j, sin1);
      cos_j    = cos_next;
      num      = {sin_j, 16'h0000};
      quo      = num / {16'h0000, cos_j};
      if (num % {16'h0000, cos_j} != 80'd0) begin
        quo = quo + 80'd1;
      end
      atan_thr[j] = quo[31:0];
    end
  end

  function automatic logic [31:0] dim_used(input logic [12:0] v);
    if (v == 13'd0) begin
      return 32'd1;
    end else if (v > 13'(MAX_DIM)) begin
      return 32'(MAX_DIM);
    end
    return {19'd0, v};
  endfunction

  // Negative levels give zero; otherwise the byte is how many thresholds the
  // Q16.16 product reaches.
  function automatic logic [7:0] tone_byte(input logic [15:0] lvl);
    logic [31:0] prod;
    logic [7:0]  hits;
    hits = 8'd0;
    if (lvl[15]) begin
      return 8'd0;
    end
    prod = {16'd0, lvl} * {16'd0, gain_q};
    for (int j = 0; j < ROM_SIZE; j++) begin
      if (prod >= atan_thr[j]) begin
        hits = hits + 8'd1;
      end
    end
    return hits;
  endfunction

  task automatic queue_pixel(input logic [15:0] red, input logic [15:0] green,
                             input logic [15:0] blue);
    logic [53:0][7:0] hdr;
    logic [31:0]      w;
    logic [31:0]      h;
    logic [31:0]      total;
    logic             done;
    w     = dim_used(width_q);
    h     = dim_used(height_q);
    total = w * h;
    if (frame_pos == 24'd0) begin
      hdr        = '0;
      hdr[0]     = MAGIC_B;
      hdr[1]     = MAGIC_M;
      hdr[5:2]   = total * 32'd3;
      hdr[13:10] = 32'(HEADER_BYTES);
      hdr[17:14] = INFO_HDR_LEN;
      hdr[21:18] = w;
      hdr[25:22] = h;
      hdr[27:26] = PLANE_COUNT;
      hdr[29:28] = COLOR_DEPTH;
      for (int k = 0; k < HEADER_BYTES; k++) begin
        stream_fifo.push_back('{data: hdr[k], last_pix: 1'b0, frame_end: 1'b0});
      end
    end
    // A frame ends once the count reaches the current total, even if the
    // dimensions shrank below it mid-frame.
    done      = ({8'd0, frame_pos} + 32'd1 >= total);
    frame_pos = done ? 24'd0 : frame_pos + 24'd1;
    if (done) begin
      frame_cnt++;
    end
    stream_fifo.push_back('{data: tone_byte(blue), last_pix: 1'b0, frame_end: 1'b0});
    stream_fifo.push_back('{data: tone_byte(green), last_pix: 1'b0, frame_end: 1'b0});
    stream_fifo.push_back('{data: tone_byte(red), last_pix: 1'b1, frame_end: done});
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
    if (fail_cnt < PRINT_CAP) begin
      $display("%0t ns: byte %0d of the stream: %s is %h, expected %h",
               $time, byte_cnt, what, got, exp_val);
    end
    fail_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   = 13'd1;
      height_q  = 13'd1;
      gain_q    = 16'd256;
      frame_pos = 24'd0;
      stream_fifo.delete();
      fail_cnt  = 0;
      pix_cnt   = 0;
      byte_cnt  = 0;
      frame_cnt = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
      pixels_o     <= 0;
      bytes_o      <= 0;
      frames_o     <= 0;
    end else begin
      if (cfg_we_i === 1'b1) begin
        case (cfg_idx_i)
          CFG_WIDTH: begin
            width_q = cfg_data_i[12:0];
          end
          CFG_HEIGHT: begin
            height_q = cfg_data_i[12:0];
          end
          CFG_GAIN: begin
            gain_q = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (pix_i.valid === 1'b1 && pix_i.ready === 1'b1) begin
        queue_pixel(pix_i.red_level, pix_i.green_level, pix_i.blue_level);
        pix_cnt++;
      end
      if (byte_i.valid === 1'b1 && byte_i.ready === 1'b1) begin
        if (stream_fifo.size() == 0) begin
          report_mismatch("unexpected byte", byte_i.out_byte, 8'h00);
        end else begin
          want = stream_fifo.pop_front();
          if (byte_i.out_byte !== want.data) begin
            report_mismatch("out_byte", byte_i.out_byte, want.data);
          end
          if (byte_i.last_of_item !== want.last_pix) begin
            report_mismatch("last_of_item", {7'd0, byte_i.last_of_item}, {7'd0, want.last_pix});
          end
          if (byte_i.frame_done !== want.frame_end) begin
            report_mismatch("frame_done", {7'd0, byte_i.frame_done}, {7'd0, want.frame_end});
          end
        end
        byte_cnt++;
      end
      mismatches_o <= fail_cnt;
      pending_o    <= stream_fifo.size();
      pixels_o     <= pix_cnt;
      bytes_o      <= byte_cnt;
      frames_o     <= frame_cnt;
    end
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

// Top of the BMP stream writer bench. This module only makes stimulus and
// gives the verdict; bmpw_stream_checker predicts and compares the bytes.
module tb_top;
  import bmpw_pkg::*;

  // Pacing of the two channels, in percent of cycles spent idle.
  localparam int SLOW_PCT      = 78;
  localparam int BUSY_PCT      = 38;
  // Random part: phases of pixels, each under a fresh register setting.
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_PIXELS  = 25;
  // Phase in which the receiver holds off long enough to back the pixel
  // input up, and the length of that hold-off.
  localparam int HOLD_PHASE    = 8;
  localparam int LONG_HOLD     = 400;
  // Cycles without any transfer before the run is declared hung. The longest
  // quiet stretch in a correct run is the long hold-off above.
  localparam int QUIET_LIMIT   = 5000;
  // Length of the tail that is watched for stray bytes once nothing is expected.
  localparam int TAIL_CYCLES   = 20;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_req;
  int          hold_seen;
  int          hold_left;
  int          quiet_cycles;
  int          settings_used;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned pixels_seen;
  int unsigned bytes_seen;
  int unsigned frames_seen;

  bmpw_pix_if  pix_ch ();
  bmpw_byte_if byte_ch ();

  bmp_stream_writer_atan_tonemap_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .pix_i      (pix_ch),
    .byte_o     (byte_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  bmpw_stream_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .pix_i        (pix_ch),
    .byte_i       (byte_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .pixels_o     (pixels_seen),
    .bytes_o      (bytes_seen),
    .frames_o     (frames_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver. A long hold-off is requested by bumping hold_req; the
  // hold-off itself is counted here so the sender can keep offering pixels.
  initial begin
    byte_ch.ready <= 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        byte_ch.ready <= 1'b0;
      end else begin
        byte_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // The watchdog counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) ||
        (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("No transfer for %0d cycles, %0d bytes still expected.", quiet_cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offers one pixel after a random gap and returns at the edge of its
  // transfer. Valid stays high when the next pixel follows without a gap.
  task automatic send_pixel(input logic [15:0] red, input logic [15:0] green,
                            input logic [15:0] blue);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.red_level   <= red;
    pix_ch.green_level <= green;
    pix_ch.blue_level  <= blue;
    do begin
      @(posedge clk);
    end while (pix_ch.ready !== 1'b1);
  endtask

  // The sender pauses until every predicted byte has come out.
  task automatic drain();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [15:0] w, input logic [15:0] h,
                           input logic [15:0] gain);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_GAIN, gain);
    settings_used++;
  endtask

  // Dimensions are mostly small so frames complete often; now and then zero,
  // the maximum, values above it, or any 16-bit pattern.
  function automatic logic [15:0] pick_dim(input int small_max);
    case ($urandom_range(0, 19))
      0: return 16'd0;
      1: return 16'(MAX_DIM);
      2: return 16'($urandom_range(MAX_DIM + 1, 8191));
      3: return 16'($urandom);
      default: return 16'($urandom_range(1, small_max));
    endcase
  endfunction

  // Small gains keep the products on the steep part of the curve; large ones
  // push most positive levels into saturation.
  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 2))
      0: return 16'($urandom_range(0, 1023));
      1: return 16'($urandom_range(256, 4096));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1023));
      2: return 16'($urandom_range(0, 16383));
      default: return 16'($urandom_range(32768, 65535));
    endcase
  endfunction

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= CFG_WIDTH;
    cfg_data           <= '0;
    pix_ch.valid       <= 1'b0;
    pix_ch.red_level   <= '0;
    pix_ch.green_level <= '0;
    pix_ch.blue_level  <= '0;
    hold_req      = 0;
    quiet_cycles  = 0;
    settings_used = 1;
    send_idle_pct = BUSY_PCT;
    recv_idle_pct = SLOW_PCT;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Reset leaves a 1x1 frame at unity gain, so every pixel
    // here carries its own header: zero, full scale, and negatives including the
    // most negative level.
    send_pixel(16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_pixel(16'hFFFF, 16'h8000, 16'hFF00);
    drain();

    // Zero gain maps every level to black.
    write_reg(CFG_GAIN, 16'h0000);
    send_pixel(16'h7FFF, 16'h0100, 16'h0001);
    drain();

    // Full gain: the smallest positive levels already climb the curve.
    write_reg(CFG_GAIN, 16'hFFFF);
    send_pixel(16'h0001, 16'h0002, 16'h0003);
    send_pixel(16'h5555, 16'h2AAA, 16'hAAAA);
    drain();

    // Zero dimensions are taken as one.
    set_frame(16'h0000, 16'h0000, 16'h0100);
    send_pixel(16'h00FF, 16'h0100, 16'h7F00);
    drain();

    // Oversized dimensions saturate at the maximum in the header. Two pixels
    // into that frame the size shrinks to 2x1, so the next pixel ends it
    // straight away; two full 2x1 frames follow.
    set_frame(16'hFFFF, 16'(MAX_DIM), 16'h0200);
    send_pixel(16'h0180, 16'h0040, 16'h1000);
    send_pixel(16'h0000, 16'h7FFF, 16'h8001);
    drain();
    set_frame(16'd2, 16'd1, 16'h0200);
    repeat (5) begin
      send_pixel(pick_level(), pick_level(), pick_level());
    end
    drain();

    // Random part: three pacing modes, a fresh setting per phase. Register
    // writes land wherever the frame happens to be, so mid-frame size
    // changes occur naturally.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase / 4)
        0: begin
          send_idle_pct = BUSY_PCT;
          recv_idle_pct = SLOW_PCT;
        end
        1: begin
          send_idle_pct = SLOW_PCT;
          recv_idle_pct = BUSY_PCT;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      drain();
      set_frame(pick_dim(6), pick_dim(4), pick_gain());
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if (phase == HOLD_PHASE && i == 4) begin
          hold_req++;
        end
        send_pixel(pick_level(), pick_level(), pick_level());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d pixels under %0d register settings; checked %0d bytes, %0d frames.",
             pixels_seen, settings_used, bytes_seen, frames_seen);
    $display("Pacing covered slow and fast sides both ways, no idling, and a long stall.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/bmpw_pkg.sv
src/bmpw_if.sv
src/bmpw_tone_map.sv
src/bmp_stream_writer_atan_tonemap_top.sv
bench/bmpw_stream_checker.sv
bench/tb_top.sv
